// ===== hdl/assert_macros.svh =====
// Assertion helpers shared by the RTL. They compile to nothing for synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg)

`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

// ===== hdl/bdlp_pkg.sv =====
package bdlp_pkg;

    localparam int NUM_BUTTONS = 3;
    localparam int CNT_W       = 16;
    localparam int CFG_W       = 16;
    localparam int CFG_ADDR_W  = 2;
    localparam int OPCODE_W    = 2;
    localparam int IDX_W       = 2;

    localparam int IN_DATA_W  = ((NUM_BUTTONS + IDX_W + 7) / 8) * 8;
    localparam int OUT_DATA_W = ((1 + 2 * NUM_BUTTONS + 7) / 8) * 8;

    typedef logic [OPCODE_W-1:0]    t_opcode;
    typedef logic [CFG_ADDR_W-1:0]  t_cfg_addr;
    typedef logic [CNT_W-1:0]       t_count;
    typedef logic [NUM_BUTTONS-1:0] t_btn_vec;

    localparam t_opcode OP_TICK       = 2'd0;
    localparam t_opcode OP_READ_PRESS = 2'd1;
    localparam t_opcode OP_READ_LONG  = 2'd2;

    localparam t_cfg_addr CFG_HOLD_TICKS    = 2'd0;
    localparam t_cfg_addr CFG_REPEAT_TICKS  = 2'd1;
    localparam t_cfg_addr CFG_PRESSED_LEVEL = 2'd2;

    localparam t_count RST_HOLD_TICKS   = 16'd100;
    localparam t_count RST_REPEAT_TICKS = 16'd50;
    localparam logic   RST_PRESSED      = 1'b0;
    localparam logic   RST_RELEASED     = 1'b1;
    localparam t_count CNT_MAX          = {CNT_W{1'b1}};

endpackage

// ===== hdl/button_debounce_long_press.sv =====
// Debouncer for NUM_BUTTONS push buttons with long-press and auto-repeat flags.
// Input stream (s_axis): tuser carries the opcode, tdata the pin levels and the
// button index. A tick shifts one sampled level per button into a three-deep
// history; a level is taken once three samples agree. A press sets the press
// flag, holding it past hold_ticks sets the long flag, and while long the press
// flag is raised again after each hold past repeat_ticks. Read items return
// the press flag of one button (and clear it) or its long flag.
// Output stream (m_axis): one transfer per input item, with the requested flag
// and the press and long flags of all buttons after the item.
// The output is valid in the cycle after an input transfer, and one item is
// taken every cycle. The single output register sets this: a new item is taken
// whenever that register is empty or is being emptied in the same cycle, so a
// stalled receiver stops the input only while a result is waiting.
// Reset (synchronous, active low) loads the register defaults, puts every
// sample history to the released level and clears counters and flags.
// Configuration writes through i_cfg_we take effect at once and are meant to
// happen while no item is in flight.
module button_debounce_long_press (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  bdlp_pkg::t_cfg_addr               i_cfg_addr,
    input  logic [bdlp_pkg::CFG_W-1:0]        i_cfg_data,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // tdata, from bit 0: pin_levels, button_index, zero pad
    input  logic [bdlp_pkg::IN_DATA_W-1:0]    s_axis_tdata,
    // tuser: opcode
    input  bdlp_pkg::t_opcode                 s_axis_tuser,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // tdata, from bit 0: flag_value, press_flags, long_flags, zero pad
    output logic [bdlp_pkg::OUT_DATA_W-1:0]   m_axis_tdata
);

    localparam int NB = bdlp_pkg::NUM_BUTTONS;

    // Configuration registers
    bdlp_pkg::t_count r_hold_ticks;
    bdlp_pkg::t_count r_repeat_ticks;
    logic             r_pressed_level;

    // Per-button state
    bdlp_pkg::t_btn_vec r_smp_old, r_smp_mid, r_smp_new, r_acc;
    bdlp_pkg::t_btn_vec r_press, r_long;
    bdlp_pkg::t_count   r_cnt [NB];

    bdlp_pkg::t_btn_vec n_smp_old, n_smp_mid, n_smp_new, n_acc;
    bdlp_pkg::t_btn_vec n_press, n_long;
    bdlp_pkg::t_count   n_cnt [NB];
    logic               n_flag;

    // Output register
    logic                             r_out_valid;
    logic [bdlp_pkg::OUT_DATA_W-1:0]  r_out_data;

    logic                                   w_in_xfer;
    bdlp_pkg::t_btn_vec                     w_pins;
    logic [bdlp_pkg::IDX_W-1:0]             w_idx;
    bdlp_pkg::t_opcode                      w_op;

    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign w_in_xfer     = s_axis_tvalid && s_axis_tready;
    assign w_pins        = s_axis_tdata[NB-1:0];
    assign w_idx         = s_axis_tdata[NB +: bdlp_pkg::IDX_W];
    assign w_op          = s_axis_tuser;

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold_ticks    <= bdlp_pkg::RST_HOLD_TICKS;
            r_repeat_ticks  <= bdlp_pkg::RST_REPEAT_TICKS;
            r_pressed_level <= bdlp_pkg::RST_PRESSED;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                bdlp_pkg::CFG_HOLD_TICKS:    r_hold_ticks    <= i_cfg_data;
                bdlp_pkg::CFG_REPEAT_TICKS:  r_repeat_ticks  <= i_cfg_data;
                bdlp_pkg::CFG_PRESSED_LEVEL: r_pressed_level <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        logic   lvl;
        logic   pl;
        lvl       = 1'b0;
        pl        = r_pressed_level;
        n_smp_old = r_smp_old;
        n_smp_mid = r_smp_mid;
        n_smp_new = r_smp_new;
        n_acc     = r_acc;
        n_press   = r_press;
        n_long    = r_long;
        n_flag    = 1'b0;
        for (int b = 0; b < NB; b++) begin
            n_cnt[b] = r_cnt[b];
        end

        unique case (w_op)
            bdlp_pkg::OP_TICK: begin
                for (int b = 0; b < NB; b++) begin
                    lvl          = w_pins[b];
                    n_smp_old[b] = r_smp_mid[b];
                    n_smp_mid[b] = r_smp_new[b];
                    n_smp_new[b] = lvl;
                    if ((r_smp_mid[b] != r_smp_new[b]) || (r_smp_new[b] != lvl)) begin
                        n_long[b] = 1'b0;
                    end else if (r_acc[b] != lvl) begin
                        n_acc[b] = lvl;
                        if (lvl == pl) begin
                            n_cnt[b]   = '0;
                            n_press[b] = 1'b1;
                        end
                    end else if (lvl == pl) begin
                        if (r_cnt[b] != bdlp_pkg::CNT_MAX) begin
                            n_cnt[b] = r_cnt[b] + 1'b1;
                        end
                        // The limit switches to the repeat interval once long.
                        if (n_cnt[b] > (r_long[b] ? r_repeat_ticks : r_hold_ticks)) begin
                            n_long[b] = 1'b1;
                            n_acc[b]  = ~pl;
                        end
                    end
                end
            end
            bdlp_pkg::OP_READ_PRESS: begin
                for (int b = 0; b < NB; b++) begin
                    if (int'(w_idx) == b) begin
                        n_flag     = r_press[b];
                        n_press[b] = 1'b0;
                    end
                end
            end
            bdlp_pkg::OP_READ_LONG: begin
                for (int b = 0; b < NB; b++) begin
                    if (int'(w_idx) == b) begin
                        n_flag = r_long[b];
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_smp_old <= {NB{bdlp_pkg::RST_RELEASED}};
            r_smp_mid <= {NB{bdlp_pkg::RST_RELEASED}};
            r_smp_new <= {NB{bdlp_pkg::RST_RELEASED}};
            r_acc     <= {NB{bdlp_pkg::RST_RELEASED}};
            r_press   <= '0;
            r_long    <= '0;
            for (int b = 0; b < NB; b++) begin
                r_cnt[b] <= '0;
            end
        end else if (w_in_xfer) begin
            r_smp_old <= n_smp_old;
            r_smp_mid <= n_smp_mid;
            r_smp_new <= n_smp_new;
            r_acc     <= n_acc;
            r_press   <= n_press;
            r_long    <= n_long;
            for (int b = 0; b < NB; b++) begin
                r_cnt[b] <= n_cnt[b];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_out_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_xfer) begin
            r_out_data <= bdlp_pkg::OUT_DATA_W'({n_long, n_press, n_flag});
        end
    end

    `include "assert_macros.svh"

    `ASSERT_NEXT(a_out_after_in, i_clk, i_rst_n, w_in_xfer, r_out_valid, "no result after input transfer")
    `ASSERT_NEXT(a_long_only_on_tick, i_clk, i_rst_n, !(w_in_xfer && (w_op == bdlp_pkg::OP_TICK)), (r_long & ~$past(r_long)) == '0, "long flag set without a tick")
    `ASSERT_NEXT(a_press_only_on_tick, i_clk, i_rst_n, !(w_in_xfer && (w_op == bdlp_pkg::OP_TICK)), (r_press & ~$past(r_press)) == '0, "press flag set without a tick")
    `ASSERT_IMPLY(a_hold_output, i_clk, i_rst_n, r_out_valid && !m_axis_tready, !s_axis_tready, "input taken while result stalled")

endmodule

// ===== tb/sv/button_debounce_long_press_test.sv =====
module button_debounce_long_press_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int                  NB             = bdlp_pkg::NUM_BUTTONS;
    localparam bdlp_pkg::t_opcode   OP_UNUSED      = 2'd3;
    localparam bdlp_pkg::t_cfg_addr CFG_UNUSED     = 2'd3;
    localparam int                  WATCHDOG_LIMIT = 2000;
    localparam int                  PHASE_ITEMS    = 430;
    localparam int                  HELD_TICKS     = 120;

    typedef struct packed {
        bdlp_pkg::t_btn_vec long_flags;
        bdlp_pkg::t_btn_vec press_flags;
        logic               flag_value;
    } t_result;

    logic                            i_clk         = 1'b0;
    logic                            i_rst_n       = 1'b0;
    logic                            i_cfg_we      = 1'b0;
    bdlp_pkg::t_cfg_addr             i_cfg_addr    = '0;
    logic [bdlp_pkg::CFG_W-1:0]      i_cfg_data    = '0;
    logic                            s_axis_tvalid = 1'b0;
    logic                            s_axis_tready;
    // tdata, from bit 0: pin_levels, button_index, zero pad
    logic [bdlp_pkg::IN_DATA_W-1:0]  s_axis_tdata  = '0;
    // tuser: opcode
    bdlp_pkg::t_opcode               s_axis_tuser  = bdlp_pkg::OP_TICK;
    logic                            m_axis_tvalid;
    logic                            m_axis_tready = 1'b0;
    // tdata, from bit 0: flag_value, press_flags, long_flags, zero pad
    logic [bdlp_pkg::OUT_DATA_W-1:0] m_axis_tdata;

    button_debounce_long_press dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // Shadow copy of the debouncer state and its registers.
    bdlp_pkg::t_count   hold_lim   = bdlp_pkg::RST_HOLD_TICKS;
    bdlp_pkg::t_count   repeat_lim = bdlp_pkg::RST_REPEAT_TICKS;
    logic               press_lvl  = bdlp_pkg::RST_PRESSED;
    bdlp_pkg::t_btn_vec smp_old    = {NB{bdlp_pkg::RST_RELEASED}};
    bdlp_pkg::t_btn_vec smp_mid    = {NB{bdlp_pkg::RST_RELEASED}};
    bdlp_pkg::t_btn_vec smp_new    = {NB{bdlp_pkg::RST_RELEASED}};
    bdlp_pkg::t_btn_vec acc_lvl    = {NB{bdlp_pkg::RST_RELEASED}};
    bdlp_pkg::t_btn_vec press_f    = '0;
    bdlp_pkg::t_btn_vec long_f     = '0;
    bdlp_pkg::t_count   hold_cnt [NB] = '{default: '0};

    t_result expected_flags[$];
    t_result want;
    int      errors        = 0;
    int      stuck_cycles  = 0;
    int      snd_idle_pct  = 0;
    int      rcv_stall_pct = 0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic t_result step_buttons(bdlp_pkg::t_opcode op,
                                             bdlp_pkg::t_btn_vec pins,
                                             logic [bdlp_pkg::IDX_W-1:0] idx);
        t_result          r;
        bdlp_pkg::t_count lim;
        int               b;
        r = '0;
        case (op)
            bdlp_pkg::OP_TICK: begin
                for (b = 0; b < NB; b++) begin
                    smp_old[b] = smp_mid[b];
                    smp_mid[b] = smp_new[b];
                    smp_new[b] = pins[b];
                    if (smp_old[b] != smp_mid[b] || smp_mid[b] != smp_new[b]) begin
                        long_f[b] = 1'b0;
                    end else if (acc_lvl[b] != pins[b]) begin
                        acc_lvl[b] = pins[b];
                        if (pins[b] == press_lvl) begin
                            hold_cnt[b] = '0;
                            press_f[b]  = 1'b1;
                        end
                    end else if (pins[b] == press_lvl) begin
                        if (hold_cnt[b] != bdlp_pkg::CNT_MAX)
                            hold_cnt[b] = hold_cnt[b] + 1'b1;
                        lim = long_f[b] ? repeat_lim : hold_lim;
                        // Passing the limit forces a release so the next
                        // agreeing sample counts as a fresh press.
                        if (hold_cnt[b] > lim) begin
                            long_f[b]  = 1'b1;
                            acc_lvl[b] = ~press_lvl;
                        end
                    end
                end
            end
            bdlp_pkg::OP_READ_PRESS: begin
                if (idx < NB) begin
                    r.flag_value = press_f[idx];
                    press_f[idx] = 1'b0;
                end
            end
            bdlp_pkg::OP_READ_LONG: begin
                if (idx < NB)
                    r.flag_value = long_f[idx];
            end
            default: ;
        endcase
        r.press_flags = press_f;
        r.long_flags  = long_f;
        return r;
    endfunction

    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= rcv_stall_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_flags.size() == 0) begin
                $error("result transfer with nothing expected: tdata %h", m_axis_tdata);
                errors++;
            end else begin
                want = expected_flags.pop_front();
                if (m_axis_tdata[0] !== want.flag_value) begin
                    $error("flag_value: expected %b, got %b",
                           want.flag_value, m_axis_tdata[0]);
                    errors++;
                end
                if (m_axis_tdata[NB:1] !== want.press_flags) begin
                    $error("press_flags: expected %b, got %b",
                           want.press_flags, m_axis_tdata[NB:1]);
                    errors++;
                end
                if (m_axis_tdata[2*NB:NB+1] !== want.long_flags) begin
                    $error("long_flags: expected %b, got %b",
                           want.long_flags, m_axis_tdata[2*NB:NB+1]);
                    errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            stuck_cycles <= 0;
        else
            stuck_cycles <= stuck_cycles + 1;
        if (stuck_cycles == WATCHDOG_LIMIT) begin
            $display("button_debounce_long_press verification failed");
            $finish;
        end
    end

    task automatic send_item(bdlp_pkg::t_opcode op, bdlp_pkg::t_btn_vec pins,
                             logic [bdlp_pkg::IDX_W-1:0] idx);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= bdlp_pkg::IN_DATA_W'({idx, pins});
        do @(posedge i_clk); while (!s_axis_tready);
        expected_flags.push_back(step_buttons(op, pins, idx));
        while ($urandom_range(99) < snd_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
    endtask

    // Stops the sender and lets every outstanding result drain.
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (expected_flags.size() != 0)
            @(posedge i_clk);
        repeat (2) @(posedge i_clk);
    endtask

    task automatic write_reg(bdlp_pkg::t_cfg_addr addr, logic [bdlp_pkg::CFG_W-1:0] value);
        drain_results();
        i_cfg_we   <= 1'b1;
        i_cfg_addr <= addr;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (addr)
            bdlp_pkg::CFG_HOLD_TICKS:    hold_lim   = value;
            bdlp_pkg::CFG_REPEAT_TICKS:  repeat_lim = value;
            bdlp_pkg::CFG_PRESSED_LEVEL: press_lvl  = value[0];
            default: ;
        endcase
    endtask

    task automatic test_reset_state();
        int i;
        snd_idle_pct  = 0;
        rcv_stall_pct = 0;
        for (i = 0; i < 4; i++)
            send_item(bdlp_pkg::OP_READ_PRESS, '0, bdlp_pkg::IDX_W'(i));
        send_item(bdlp_pkg::OP_READ_LONG, '0, 2'd0);
        send_item(OP_UNUSED, '1, 2'd1);
        // Default pressed level is low, so all-zero pins press every button.
        repeat (3) send_item(bdlp_pkg::OP_TICK, '0, 2'd0);
        send_item(bdlp_pkg::OP_READ_PRESS, '0, 2'd1);
        send_item(bdlp_pkg::OP_READ_PRESS, '0, 2'd1);
        send_item(OP_UNUSED, '0, 2'd0);
        send_item(bdlp_pkg::OP_READ_PRESS, '0, 2'd3);
        send_item(bdlp_pkg::OP_READ_LONG, '1, 2'd3);
        send_item(bdlp_pkg::OP_TICK, 3'b101, 2'd3);
        send_item(bdlp_pkg::OP_TICK, 3'b010, 2'd2);
        send_item(bdlp_pkg::OP_TICK, '1, 2'd1);
    endtask

    task automatic test_tiny_limits();
        int i;
        write_reg(bdlp_pkg::CFG_HOLD_TICKS, 16'd0);
        write_reg(bdlp_pkg::CFG_REPEAT_TICKS, 16'd0);
        // Only bit 0 of the level register counts.
        write_reg(bdlp_pkg::CFG_PRESSED_LEVEL, 16'hFFFE);
        write_reg(CFG_UNUSED, 16'h1234);
        for (i = 0; i < 8; i++) begin
            send_item(bdlp_pkg::OP_TICK, '0, 2'd0);
            send_item(bdlp_pkg::OP_READ_LONG, '0, bdlp_pkg::IDX_W'(i % 3));
        end
        write_reg(bdlp_pkg::CFG_PRESSED_LEVEL, 16'h0001);
        repeat (5) send_item(bdlp_pkg::OP_TICK, '1, 2'd0);
        send_item(bdlp_pkg::OP_READ_PRESS, '0, 2'd2);
        send_item(bdlp_pkg::OP_READ_LONG, '0, 2'd2);
        repeat (2) send_item(bdlp_pkg::OP_TICK, '0, 2'd0);
    endtask

    // With the largest hold limit a held button gives one press and no long
    // flag, even though the repeat interval is short.
    task automatic test_largest_limit();
        int i;
        write_reg(bdlp_pkg::CFG_HOLD_TICKS, bdlp_pkg::CNT_MAX);
        write_reg(bdlp_pkg::CFG_REPEAT_TICKS, 16'd1);
        write_reg(bdlp_pkg::CFG_PRESSED_LEVEL, 16'd0);
        repeat (4) send_item(bdlp_pkg::OP_TICK, '1, 2'd0);
        repeat (HELD_TICKS) send_item(bdlp_pkg::OP_TICK, '0, 2'd0);
        for (i = 0; i < NB; i++) begin
            send_item(bdlp_pkg::OP_READ_LONG, '0, bdlp_pkg::IDX_W'(i));
            send_item(bdlp_pkg::OP_READ_PRESS, '0, bdlp_pkg::IDX_W'(i));
        end
    endtask

    task automatic test_button_traffic(int snd_pct, int rcv_pct, int n_items);
        bdlp_pkg::t_btn_vec held;
        bdlp_pkg::t_btn_vec bounce;
        bdlp_pkg::t_opcode  op;
        int                 k;
        int                 b;
        snd_idle_pct  = snd_pct;
        rcv_stall_pct = rcv_pct;
        held = bdlp_pkg::t_btn_vec'($urandom);
        for (k = 0; k < n_items; k++) begin
            if (k == n_items / 2)
                drain_results();
            if ($urandom_range(99) < 70) begin
                if ($urandom_range(99) < 6)
                    held[$urandom_range(NB - 1)] ^= 1'b1;
                bounce = '0;
                for (b = 0; b < NB; b++)
                    bounce[b] = ($urandom_range(99) < 8);
                send_item(bdlp_pkg::OP_TICK, held ^ bounce, bdlp_pkg::IDX_W'($urandom));
            end else begin
                case ($urandom_range(9))
                    0:       op = OP_UNUSED;
                    1, 2, 3: op = bdlp_pkg::OP_READ_LONG;
                    default: op = bdlp_pkg::OP_READ_PRESS;
                endcase
                send_item(op, bdlp_pkg::t_btn_vec'($urandom),
                          bdlp_pkg::IDX_W'($urandom_range(3)));
            end
        end
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_state();
        test_tiny_limits();
        test_largest_limit();

        write_reg(bdlp_pkg::CFG_PRESSED_LEVEL, 16'd0);
        write_reg(bdlp_pkg::CFG_HOLD_TICKS, 16'd3);
        write_reg(bdlp_pkg::CFG_REPEAT_TICKS, 16'd1);
        test_button_traffic(0, 0, PHASE_ITEMS);

        write_reg(bdlp_pkg::CFG_PRESSED_LEVEL, 16'd1);
        write_reg(bdlp_pkg::CFG_HOLD_TICKS, 16'd1);
        write_reg(bdlp_pkg::CFG_REPEAT_TICKS, 16'd2);
        test_button_traffic(48, 0, PHASE_ITEMS);

        write_reg(bdlp_pkg::CFG_PRESSED_LEVEL, 16'd0);
        write_reg(bdlp_pkg::CFG_HOLD_TICKS, 16'd10);
        write_reg(bdlp_pkg::CFG_REPEAT_TICKS, 16'd5);
        test_button_traffic(0, 48, PHASE_ITEMS);

        write_reg(bdlp_pkg::CFG_PRESSED_LEVEL, 16'd1);
        write_reg(bdlp_pkg::CFG_HOLD_TICKS, 16'd20);
        write_reg(bdlp_pkg::CFG_REPEAT_TICKS, bdlp_pkg::CNT_MAX);
        test_button_traffic(21, 21, PHASE_ITEMS);

        drain_results();
        repeat (5) @(posedge i_clk);
        if (errors == 0)
            $display("button_debounce_long_press verification clean");
        else
            $display("button_debounce_long_press verification failed");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+hdl
hdl/bdlp_pkg.sv
hdl/button_debounce_long_press.sv
tb/sv/button_debounce_long_press_test.sv
